// ===== src/fsp_pkg.sv =====
package fsp_pkg;

	localparam logic [31:0] TEXT_RESET = 32'h0040_0000;

	localparam logic REG_TEXT_START = 1'b0;
	localparam logic REG_TEXT_END   = 1'b1;

	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2B;

	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	localparam logic [4:0] REG_LINK = 5'd31;

	typedef enum logic [3:0] {
		K_ADD, K_R, K_EQ, K_NE, K_LUI, K_ORI, K_SLTIU, K_ANDI, K_LINK
	} kind_t;

	typedef struct packed {
		logic [31:0] word;
		logic [31:0] next_pc;
		logic        valid;
	} fd_t;

	typedef struct packed {
		logic [31:0] rs_val;
		logic [31:0] rt_val;
		logic [31:0] imm;
		logic [31:0] next_pc;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  dest;
		kind_t       kind;
		logic        valid;
		logic        reg_write;
		logic        mem_read;
		logic        store_op;
		logic        mem_to_reg;
		logic        alu_imm;
		logic        branch;
	} de_t;

	typedef struct packed {
		logic [31:0] result;
		logic [31:0] store_val;
		logic [4:0]  dest;
		logic        valid;
		logic        reg_write;
		logic        mem_read;
		logic        store_op;
		logic        mem_to_reg;
		logic        taken;
	} em_t;

	typedef struct packed {
		logic [31:0] alu;
		logic [31:0] mem;
		logic [4:0]  dest;
		logic        valid;
		logic        reg_write;
		logic        mem_to_reg;
	} mw_t;

endpackage

// ===== src/fsp_in_if.sv =====
interface fsp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instr_word;
	logic [31:0] load_word;

	modport source (output valid, output instr_word, output load_word, input ready);
	modport sink (input valid, input instr_word, input load_word, output ready);
endinterface

// ===== src/fsp_out_if.sv =====
interface fsp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] fetch_addr;
	logic [31:0] load_addr;
	logic        load_request;
	logic        store_enable;
	logic [31:0] store_addr;
	logic [31:0] store_data;
	logic        retired;
	logic        halted;

	modport source (output valid, output fetch_addr, output load_addr, output load_request,
		output store_enable, output store_addr, output store_data, output retired,
		output halted, input ready);
	modport sink (input valid, input fetch_addr, input load_addr, input load_request,
		input store_enable, input store_addr, input store_data, input retired,
		input halted, output ready);
endinterface

// ===== src/five_stage_pipelined_core.sv =====
// result: an item's result is registered and shown in the cycle after the item is accepted
// throughput: one item per cycle while the receiver takes results; each item is one tick of the five-stage pipeline
// the register file is read as the word enters the fetch latch, through registered ports, with write-first bypass
// arst_n clears the stage latches, pc to text_start reset value, register file valid bits
// and the result valid flag; no clearing pass is needed
module five_stage_pipelined_core (
	input  logic        clk,
	input  logic        arst_n,
	fsp_in_if.sink      in_ch,
	fsp_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] text_start_q, text_end_q, pc_q;
	fsp_pkg::fd_t fd_q;
	fsp_pkg::de_t de_q;
	fsp_pkg::em_t em_q;
	fsp_pkg::mw_t mw_q;
	logic jp_q;

	logic [31:0] rf_q [32];
	logic [31:0] vld_q;
	logic [31:0] rs_mem_q, rt_mem_q;
	logic        rs_ok_q, rt_ok_q;

	logic        ovld_q;
	logic [31:0] fetch_addr_q, load_addr_q, store_addr_q, store_data_q;
	logic        load_request_q, store_enable_q, retired_q, halted_q;

	logic accept, cfg_wr;

	fsp_pkg::fd_t nfd;
	fsp_pkg::de_t nde;
	fsp_pkg::em_t nem;
	fsp_pkg::mw_t nmw;
	logic        jp_d, hazard, jumped, squash, fetch_ok, wen, st_en;
	logic [31:0] wb_val, st_data, jump_to, br_to, pc_d;
	logic [4:0]  rd_rs, rd_rt;

	function automatic logic [31:0] pick(input logic [4:0] r, input logic [31:0] held,
		input fsp_pkg::em_t b, input fsp_pkg::mw_t a, input logic [31:0] a_val);
		if (r != 5'd0 && b.reg_write && !b.mem_to_reg && b.dest == r) return b.result;
		if (r != 5'd0 && a.reg_write && a.dest == r) return a_val;
		return held;
	endfunction

	function automatic logic [31:0] rtype(input logic [5:0] fn, input logic [4:0] sh,
		input logic [31:0] a, input logic [31:0] b);
		case (fn)
			fsp_pkg::FN_SLL:  return b << sh;
			fsp_pkg::FN_SRL:  return b >> sh;
			fsp_pkg::FN_ADDU: return a + b;
			fsp_pkg::FN_SUBU: return a - b;
			fsp_pkg::FN_AND:  return a & b;
			fsp_pkg::FN_OR:   return a | b;
			fsp_pkg::FN_NOR:  return ~(a | b);
			fsp_pkg::FN_SLTU: return {31'd0, a < b};
			default:          return 32'd0;
		endcase
	endfunction

	function automatic logic rtype_known(input logic [5:0] fn);
		case (fn)
			fsp_pkg::FN_SLL, fsp_pkg::FN_SRL, fsp_pkg::FN_ADDU, fsp_pkg::FN_SUBU,
			fsp_pkg::FN_AND, fsp_pkg::FN_OR, fsp_pkg::FN_NOR, fsp_pkg::FN_SLTU: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	assign in_ch.ready = !ovld_q || out_ch.ready;
	assign accept = in_ch.valid && in_ch.ready;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == fsp_pkg::REG_TEXT_END) ? text_end_q : text_start_q;

	always_comb begin
		logic [31:0] a, bv, b, r, w, mval, rsv, rtv;
		logic        cond, uses_rt;
		logic [4:0]  rs, rt, rd;
		logic [5:0]  op, fn;
		a = '0; bv = '0; b = '0; r = '0; w = '0; mval = '0; rsv = '0; rtv = '0;
		cond = 1'b0; uses_rt = 1'b0; rs = '0; rt = '0; rd = '0; op = '0; fn = '0;
		hazard = 1'b0; jumped = 1'b0; jump_to = '0; br_to = '0;
		squash = em_q.taken;

		// writeback
		wb_val = mw_q.mem_to_reg ? mw_q.mem : mw_q.alu;
		wen = mw_q.reg_write && mw_q.dest != 5'd0;

		// memory
		st_en = em_q.store_op;
		st_data = '0;
		if (st_en)
			st_data = (mw_q.mem_to_reg && wen && mw_q.dest == em_q.dest) ? wb_val : em_q.store_val;
		nmw.valid = em_q.valid;
		nmw.alu = em_q.result;
		nmw.mem = em_q.mem_read ? in_ch.load_word : 32'd0;
		nmw.dest = em_q.dest;
		nmw.reg_write = em_q.reg_write;
		nmw.mem_to_reg = em_q.mem_to_reg;

		// execute
		nem = '0;
		if (!squash && de_q.valid) begin
			a = pick(de_q.rs, de_q.rs_val, em_q, mw_q, wb_val);
			bv = pick(de_q.rt, de_q.rt_val, em_q, mw_q, wb_val);
			b = de_q.alu_imm ? de_q.imm : bv;
			case (de_q.kind)
				fsp_pkg::K_R:     r = rtype(de_q.imm[5:0], de_q.imm[10:6], a, b);
				fsp_pkg::K_EQ:    cond = (a == b);
				fsp_pkg::K_NE:    begin r = a - b; cond = (a != b); end
				fsp_pkg::K_LUI:   r = {b[15:0], 16'd0};
				fsp_pkg::K_ORI:   r = a | {16'd0, b[15:0]};
				fsp_pkg::K_SLTIU: r = {31'd0, a < b};
				fsp_pkg::K_ANDI:  r = a & {16'd0, b[15:0]};
				fsp_pkg::K_LINK:  r = de_q.next_pc;
				default:          r = a + b;
			endcase
			br_to = de_q.next_pc + {de_q.imm[29:0], 2'b00};
			nem.valid = 1'b1;
			nem.result = r;
			nem.store_val = bv;
			nem.dest = de_q.dest;
			nem.reg_write = de_q.reg_write;
			nem.mem_read = de_q.mem_read;
			nem.store_op = de_q.store_op;
			nem.mem_to_reg = de_q.mem_to_reg;
			nem.taken = de_q.branch && cond;
		end

		// decode
		nde = '0;
		jp_d = 1'b0;
		if (!(jp_q || squash) && fd_q.valid) begin
			w = fd_q.word;
			rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
			op = w[31:26]; fn = w[5:0];
			uses_rt = (op == fsp_pkg::OP_SPECIAL && fn != fsp_pkg::FN_JR) ||
				op == fsp_pkg::OP_BEQ || op == fsp_pkg::OP_BNE;
			hazard = de_q.mem_read && (de_q.rt == rs || (uses_rt && de_q.rt == rt));
			if (!hazard) begin
				// this tick's writeback lands before the read
				rsv = (wen && mw_q.dest == rs) ? wb_val : (rs_ok_q ? rs_mem_q : 32'd0);
				rtv = (wen && mw_q.dest == rt) ? wb_val : (rt_ok_q ? rt_mem_q : 32'd0);
				nde.rs_val = rsv;
				nde.rt_val = rtv;
				nde.imm = {{16{w[15]}}, w[15:0]};
				nde.next_pc = fd_q.next_pc;
				nde.valid = 1'b1;
				nde.rs = rs; nde.rt = rt; nde.dest = rt; nde.kind = fsp_pkg::K_ADD;
				case (op)
					fsp_pkg::OP_LW: begin
						nde.mem_read = 1'b1; nde.alu_imm = 1'b1;
						nde.reg_write = 1'b1; nde.mem_to_reg = 1'b1;
					end
					fsp_pkg::OP_SW: begin nde.store_op = 1'b1; nde.alu_imm = 1'b1; end
					fsp_pkg::OP_SPECIAL: begin
						if (fn == fsp_pkg::FN_JR) begin
							mval = nmw.mem_to_reg ? nmw.mem : nmw.alu;
							jump_to = pick(rs, rsv, nem, nmw, mval);
							jumped = 1'b1;
						end else if (rtype_known(fn)) begin
							nde.kind = fsp_pkg::K_R; nde.dest = rd; nde.reg_write = 1'b1;
						end
					end
					fsp_pkg::OP_BEQ: begin nde.branch = 1'b1; nde.kind = fsp_pkg::K_EQ; end
					fsp_pkg::OP_BNE: begin nde.branch = 1'b1; nde.kind = fsp_pkg::K_NE; end
					fsp_pkg::OP_J: begin
						jump_to = {fd_q.next_pc[31:28], w[25:0], 2'b00};
						jumped = 1'b1;
					end
					fsp_pkg::OP_JAL: begin
						jump_to = {fd_q.next_pc[31:28], w[25:0], 2'b00};
						jumped = 1'b1;
						nde.kind = fsp_pkg::K_LINK; nde.dest = fsp_pkg::REG_LINK;
						nde.reg_write = 1'b1;
					end
					fsp_pkg::OP_ADDIU: begin nde.reg_write = 1'b1; nde.alu_imm = 1'b1; end
					fsp_pkg::OP_LUI: begin
						nde.reg_write = 1'b1; nde.alu_imm = 1'b1; nde.kind = fsp_pkg::K_LUI;
					end
					fsp_pkg::OP_ORI: begin
						nde.reg_write = 1'b1; nde.alu_imm = 1'b1; nde.kind = fsp_pkg::K_ORI;
					end
					fsp_pkg::OP_SLTIU: begin
						nde.reg_write = 1'b1; nde.alu_imm = 1'b1; nde.kind = fsp_pkg::K_SLTIU;
					end
					fsp_pkg::OP_ANDI: begin
						nde.reg_write = 1'b1; nde.alu_imm = 1'b1; nde.kind = fsp_pkg::K_ANDI;
					end
					default: ;
				endcase
				jp_d = jumped;
			end
		end

		// fetch
		fetch_ok = pc_q >= text_start_q && pc_q < text_end_q;
		pc_d = pc_q;
		nfd = '0;
		if (hazard) begin
			nfd = fd_q;
		end else if (!squash) begin
			if (fetch_ok) begin
				nfd.word = in_ch.instr_word;
				nfd.next_pc = pc_q + 32'd4;
				nfd.valid = 1'b1;
			end
			if (nem.taken) pc_d = br_to;
			else if (jumped) pc_d = jump_to;
			else if (fetch_ok) pc_d = pc_q + 32'd4;
		end

		rd_rs = nfd.word[25:21];
		rd_rt = nfd.word[20:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_start_q <= fsp_pkg::TEXT_RESET;
			text_end_q <= fsp_pkg::TEXT_RESET;
			pc_q <= fsp_pkg::TEXT_RESET;
			fd_q <= '0;
			de_q <= '0;
			em_q <= '0;
			mw_q <= '0;
			jp_q <= 1'b0;
			vld_q <= '0;
			rs_ok_q <= 1'b0;
			rt_ok_q <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == fsp_pkg::REG_TEXT_START) begin
					text_start_q <= pwdata;
				end else begin
					text_end_q <= pwdata;
				end
			end
			// writing text_start also loads the pc
			if (cfg_wr && paddr[2] == fsp_pkg::REG_TEXT_START) begin
				pc_q <= pwdata;
			end else if (accept) begin
				pc_q <= pc_d;
			end
			if (accept) begin
				fd_q <= nfd;
				de_q <= nde;
				em_q <= nem;
				mw_q <= nmw;
				jp_q <= jp_d;
				if (wen) vld_q[mw_q.dest] <= 1'b1;
				rs_ok_q <= vld_q[rd_rs] || (wen && mw_q.dest == rd_rs);
				rt_ok_q <= vld_q[rd_rt] || (wen && mw_q.dest == rd_rt);
				ovld_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// register file: one write port, two registered read ports, write-first
	always_ff @(posedge clk) begin
		if (accept) begin
			if (wen) rf_q[mw_q.dest] <= wb_val;
			rs_mem_q <= (wen && mw_q.dest == rd_rs) ? wb_val : rf_q[rd_rs];
			rt_mem_q <= (wen && mw_q.dest == rd_rt) ? wb_val : rf_q[rd_rt];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fetch_addr_q <= pc_d;
			load_addr_q <= nem.mem_read ? nem.result : 32'd0;
			load_request_q <= nem.mem_read;
			store_enable_q <= st_en;
			store_addr_q <= st_en ? em_q.result : 32'd0;
			store_data_q <= st_data;
			retired_q <= mw_q.valid;
			halted_q <= !(nfd.valid || nde.valid || nem.valid || nmw.valid);
		end
	end

	assign out_ch.valid = ovld_q;
	assign out_ch.fetch_addr = fetch_addr_q;
	assign out_ch.load_addr = load_addr_q;
	assign out_ch.load_request = load_request_q;
	assign out_ch.store_enable = store_enable_q;
	assign out_ch.store_addr = store_addr_q;
	assign out_ch.store_data = store_data_q;
	assign out_ch.retired = retired_q;
	assign out_ch.halted = halted_q;

	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_ch.valid)
		else $error("accepted item gave no result");

	a_zero_reg: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0])
		else $error("register zero was written");

	a_halt_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.halted) |-> !out_ch.load_request)
		else $error("load requested while halted");

	a_hazard_holds_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && hazard && !cfg_wr) |=> pc_q == $past(pc_q))
		else $error("pc moved during load-use stall");

endmodule

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] fetch_addr;
		logic [31:0] load_addr;
		logic        load_request;
		logic        store_enable;
		logic [31:0] store_addr;
		logic [31:0] store_data;
		logic        retired;
		logic        halted;
	} tick_res_t;

	typedef struct {
		logic [31:0] iw;
		logic [31:0] ld;
		bit          typed;
		tick_res_t   res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	fsp_in_if  in_ch();
	fsp_out_if out_ch();

	five_stage_pipelined_core i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// core model state
	logic [31:0]  text_lo, text_hi, pc;
	logic [31:0]  gpr [32];
	fsp_pkg::fd_t fd;
	fsp_pkg::de_t de;
	fsp_pkg::em_t em;
	fsp_pkg::mw_t mw;
	bit           jump_squash;

	tick_res_t   ticks_due [$];
	bit          typed_on;
	tick_res_t   typed_val;
	int          errors, accepted, results, retires, stores;
	bit          held;
	int          hold_left;

	function automatic bit calm();
		return accepted >= 500 && accepted < 700;
	endfunction

	function automatic logic [31:0] bypass(logic [4:0] r, logic [31:0] held_val,
		fsp_pkg::em_t b, fsp_pkg::mw_t a, logic [31:0] a_val);
		if (r != 0 && b.reg_write && !b.mem_to_reg && b.dest == r)
			return b.result;
		if (r != 0 && a.reg_write && a.dest == r)
			return a_val;
		return held_val;
	endfunction

	function automatic logic [31:0] r_alu(logic [5:0] fn, logic [4:0] sh, logic [31:0] a,
		logic [31:0] b);
		case (fn)
			fsp_pkg::FN_SLL:  return b << sh;
			fsp_pkg::FN_SRL:  return b >> sh;
			fsp_pkg::FN_ADDU: return a + b;
			fsp_pkg::FN_SUBU: return a - b;
			fsp_pkg::FN_AND:  return a & b;
			fsp_pkg::FN_OR:   return a | b;
			fsp_pkg::FN_NOR:  return ~(a | b);
			fsp_pkg::FN_SLTU: return {31'b0, a < b};
			default: return '0;
		endcase
	endfunction

	function automatic bit r_known(logic [5:0] fn);
		return fn == fsp_pkg::FN_SLL || fn == fsp_pkg::FN_SRL || fn == fsp_pkg::FN_ADDU ||
			fn == fsp_pkg::FN_SUBU || fn == fsp_pkg::FN_AND || fn == fsp_pkg::FN_OR ||
			fn == fsp_pkg::FN_NOR || fn == fsp_pkg::FN_SLTU;
	endfunction

	function automatic void core_reset();
		text_lo = fsp_pkg::TEXT_RESET;
		text_hi = fsp_pkg::TEXT_RESET;
		pc = fsp_pkg::TEXT_RESET;
		foreach (gpr[i]) gpr[i] = '0;
		fd = '0;
		de = '0;
		em = '0;
		mw = '0;
		jump_squash = 0;
	endfunction

	// advance the core model for one accepted item
	function automatic tick_res_t core_tick(logic [31:0] iw, logic [31:0] ld);
		tick_res_t r;
		fsp_pkg::fd_t nfd;
		fsp_pkg::de_t nde;
		fsp_pkg::em_t nem;
		fsp_pkg::mw_t nmw;
		logic [31:0] wb, a, bv, b, alu, br_to, jump_to, w, mval;
		logic [5:0] op, fn;
		logic [4:0] rs, rt, rd;
		bit squash, hazard, jumped, cond, ok, uses_rt;
		squash = em.taken;
		hazard = 0;
		jumped = 0;
		br_to = '0;
		jump_to = '0;
		r = '0;

		wb = mw.mem_to_reg ? mw.mem : mw.alu;
		if (mw.reg_write && mw.dest != 0)
			gpr[mw.dest] = wb;

		r.store_enable = em.store_op;
		if (em.store_op) begin
			r.store_addr = em.result;
			r.store_data = (mw.mem_to_reg && mw.reg_write && mw.dest != 0 &&
				mw.dest == em.dest) ? wb : em.store_val;
		end
		nmw.valid = em.valid;
		nmw.alu = em.result;
		nmw.mem = em.mem_read ? ld : '0;
		nmw.dest = em.dest;
		nmw.reg_write = em.reg_write;
		nmw.mem_to_reg = em.mem_to_reg;

		nem = '0;
		if (!squash && de.valid) begin
			a = bypass(de.rs, de.rs_val, em, mw, wb);
			bv = bypass(de.rt, de.rt_val, em, mw, wb);
			b = de.alu_imm ? de.imm : bv;
			alu = '0;
			cond = 0;
			case (de.kind)
				fsp_pkg::K_R:     alu = r_alu(de.imm[5:0], de.imm[10:6], a, b);
				fsp_pkg::K_EQ:    cond = (a == b);
				fsp_pkg::K_NE:    begin alu = a - b; cond = (a != b); end
				fsp_pkg::K_LUI:   alu = {b[15:0], 16'h0};
				fsp_pkg::K_ORI:   alu = a | {16'h0, b[15:0]};
				fsp_pkg::K_SLTIU: alu = {31'b0, a < b};
				fsp_pkg::K_ANDI:  alu = a & {16'h0, b[15:0]};
				fsp_pkg::K_LINK:  alu = de.next_pc;
				default: alu = a + b;
			endcase
			br_to = de.next_pc + (de.imm << 2);
			nem.valid = 1;
			nem.result = alu;
			nem.store_val = bv;
			nem.dest = de.dest;
			nem.reg_write = de.reg_write;
			nem.mem_read = de.mem_read;
			nem.store_op = de.store_op;
			nem.mem_to_reg = de.mem_to_reg;
			nem.taken = de.branch && cond;
		end

		nde = '0;
		if (!(jump_squash || squash) && fd.valid) begin
			jump_squash = 0;
			w = fd.word;
			rs = w[25:21];
			rt = w[20:16];
			rd = w[15:11];
			op = w[31:26];
			fn = w[5:0];
			uses_rt = (op == fsp_pkg::OP_SPECIAL && fn != fsp_pkg::FN_JR) ||
				op == fsp_pkg::OP_BEQ || op == fsp_pkg::OP_BNE;
			hazard = de.mem_read && (de.rt == rs || (uses_rt && de.rt == rt));
			if (!hazard) begin
				nde.rs_val = gpr[rs];
				nde.rt_val = gpr[rt];
				nde.imm = {{16{w[15]}}, w[15:0]};
				nde.next_pc = fd.next_pc;
				nde.valid = 1;
				nde.rs = rs;
				nde.rt = rt;
				nde.dest = rt;
				nde.kind = fsp_pkg::K_ADD;
				case (op)
					fsp_pkg::OP_LW: begin
						nde.mem_read = 1; nde.alu_imm = 1;
						nde.reg_write = 1; nde.mem_to_reg = 1;
					end
					fsp_pkg::OP_SW: begin nde.store_op = 1; nde.alu_imm = 1; end
					fsp_pkg::OP_SPECIAL:
						if (fn == fsp_pkg::FN_JR) begin
							mval = nmw.mem_to_reg ? nmw.mem : nmw.alu;
							jump_to = bypass(rs, nde.rs_val, nem, nmw, mval);
							jumped = 1;
						end else if (r_known(fn)) begin
							nde.kind = fsp_pkg::K_R; nde.dest = rd; nde.reg_write = 1;
						end
					fsp_pkg::OP_BEQ: begin nde.branch = 1; nde.kind = fsp_pkg::K_EQ; end
					fsp_pkg::OP_BNE: begin nde.branch = 1; nde.kind = fsp_pkg::K_NE; end
					fsp_pkg::OP_J, fsp_pkg::OP_JAL: begin
						jump_to = {fd.next_pc[31:28], w[25:0], 2'b00};
						jumped = 1;
						if (op == fsp_pkg::OP_JAL) begin
							nde.kind = fsp_pkg::K_LINK; nde.dest = fsp_pkg::REG_LINK;
							nde.reg_write = 1;
						end
					end
					fsp_pkg::OP_ADDIU: begin nde.reg_write = 1; nde.alu_imm = 1; end
					fsp_pkg::OP_LUI: begin
						nde.reg_write = 1; nde.alu_imm = 1; nde.kind = fsp_pkg::K_LUI;
					end
					fsp_pkg::OP_ORI: begin
						nde.reg_write = 1; nde.alu_imm = 1; nde.kind = fsp_pkg::K_ORI;
					end
					fsp_pkg::OP_SLTIU: begin
						nde.reg_write = 1; nde.alu_imm = 1; nde.kind = fsp_pkg::K_SLTIU;
					end
					fsp_pkg::OP_ANDI: begin
						nde.reg_write = 1; nde.alu_imm = 1; nde.kind = fsp_pkg::K_ANDI;
					end
					default: ;
				endcase
				if (jumped)
					jump_squash = 1;
			end
		end else
			jump_squash = 0;

		ok = pc >= text_lo && pc < text_hi;
		if (hazard)
			nfd = fd;
		else begin
			nfd = '0;
			if (!squash) begin
				if (ok) begin
					nfd.word = iw;
					nfd.next_pc = pc + 4;
					nfd.valid = 1;
				end
				if (nem.taken) pc = br_to;
				else if (jumped) pc = jump_to;
				else if (ok) pc = pc + 4;
			end
		end

		r.fetch_addr = pc;
		r.load_addr = nem.mem_read ? nem.result : '0;
		r.load_request = nem.mem_read;
		r.retired = mw.valid;
		r.halted = !(nfd.valid || nde.valid || nem.valid || nmw.valid);
		fd = nfd;
		de = nde;
		em = nem;
		mw = nmw;
		return r;
	endfunction

	always @(posedge clk) begin
		tick_res_t got, want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.fetch_addr, out_ch.load_addr, out_ch.load_request,
					out_ch.store_enable, out_ch.store_addr, out_ch.store_data,
					out_ch.retired, out_ch.halted};
				results++;
				retires += got.retired;
				stores += got.store_enable;
				if (ticks_due.size() == 0) begin
					errors++;
					$display("%t unexpected result: actual %p", $realtime, got);
				end else begin
					want = ticks_due.pop_front();
					if (got !== want) begin
						errors++;
						$display("%t expected %p actual %p", $realtime, want, got);
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				want = core_tick(in_ch.instr_word, in_ch.load_word);
				if (typed_on)
					want = typed_val;
				ticks_due.push_back(want);
				accepted++;
			end
		end
	end

	// receiver: random stalls, one long hold-off once 300 results have been taken
	always @(negedge clk) begin
		if (!held && results >= 300) begin
			held = 1;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= calm() || $urandom_range(99) >= 26;
	end

	task automatic offer(input logic [31:0] iw, input logic [31:0] ld, input bit typed,
		input tick_res_t res);
		@(negedge clk);
		while (!calm() && $urandom_range(99) < 26) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.instr_word <= iw;
		in_ch.load_word <= ld;
		typed_on <= typed;
		typed_val <= res;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (ticks_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == fsp_pkg::REG_TEXT_START) begin
			text_lo = val;
			pc = val;
		end else
			text_hi = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
		logic [4:0] rd, logic [4:0] sh);
		return {fsp_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
		logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [4:0] pick_reg();
		return $urandom_range(99) < 80 ? 5'($urandom_range(5)) : 5'($urandom_range(31));
	endfunction

	// mostly well-formed code with J and JAL targets aimed at the text window start or up to 64 words past it
	function automatic logic [31:0] rand_instr();
		logic [5:0] fns [8] = '{fsp_pkg::FN_SLL, fsp_pkg::FN_SRL, fsp_pkg::FN_ADDU,
			fsp_pkg::FN_SUBU, fsp_pkg::FN_AND, fsp_pkg::FN_OR, fsp_pkg::FN_NOR,
			fsp_pkg::FN_SLTU};
		logic [5:0] imms [5] = '{fsp_pkg::OP_ADDIU, fsp_pkg::OP_SLTIU, fsp_pkg::OP_ANDI,
			fsp_pkg::OP_ORI, fsp_pkg::OP_LUI};
		logic [31:0] span, idx;
		int sel;
		span = text_hi > text_lo ? ((text_hi - text_lo) >> 2) : 0;
		if (span > 64) span = 64;
		idx = (text_lo >> 2) + $urandom_range(span);
		sel = $urandom_range(99);
		if (sel < 30)
			return enc_r(fns[$urandom_range(7)], pick_reg(), pick_reg(), pick_reg(),
				5'($urandom_range(31)));
		if (sel < 50)
			return enc_i(imms[$urandom_range(4)], pick_reg(), pick_reg(), 16'($urandom));
		if (sel < 62)
			return enc_i(fsp_pkg::OP_LW, pick_reg(), pick_reg(), 16'($urandom_range(255)));
		if (sel < 70)
			return enc_i(fsp_pkg::OP_SW, pick_reg(), pick_reg(), 16'($urandom_range(255)));
		if (sel < 80)
			return enc_i($urandom_range(1) ? fsp_pkg::OP_BEQ : fsp_pkg::OP_BNE, pick_reg(),
				pick_reg(), 16'($urandom_range(9)) - 16'd3);
		if (sel < 86)
			return {$urandom_range(1) ? fsp_pkg::OP_J : fsp_pkg::OP_JAL, idx[25:0]};
		if (sel < 89)
			return enc_r(fsp_pkg::FN_JR, fsp_pkg::REG_LINK, 5'd0, 5'd0, 5'd0);
		return $urandom;
	endfunction

	initial begin
		row_t rows [$];
		tick_res_t idle_res;
		logic [31:0] starts [9] = '{32'h0040_0000, 32'h0, 32'hFFFF_FF00, 32'h0000_1000,
			32'h0040_0000, 32'h0000_0800, 32'h0040_0000, 32'h0, 32'h0040_0000};
		logic [31:0] ends [9] = '{32'h0040_0400, 32'h0000_0100, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h0040_0100, 32'h0, 32'h0040_0040, 32'hFFFF_FFFF, 32'h0040_0200};

		in_ch.valid = 1'b0;
		in_ch.instr_word = '0;
		in_ch.load_word = '0;
		out_ch.ready = 1'b0;
		core_reset();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty text window after reset: bubbles, pc held
		idle_res = '0;
		idle_res.fetch_addr = fsp_pkg::TEXT_RESET;
		idle_res.halted = 1'b1;
		offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, idle_res);
		offer(32'h0, 32'h0, 1'b1, idle_res);
		settle();
		reg_write(fsp_pkg::REG_TEXT_START, fsp_pkg::TEXT_RESET);
		reg_write(fsp_pkg::REG_TEXT_END, fsp_pkg::TEXT_RESET + 32'h100);

		rows = '{
			'{enc_i(fsp_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h8000), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_ADDU, 5'd1, 5'd2, 5'd3, 5'd0), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_SUBU, 5'd0, 5'd1, 5'd3, 5'd0), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_AND, 5'd1, 5'd2, 5'd4, 5'd0), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_OR, 5'd2, 5'd3, 5'd4, 5'd0), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_NOR, 5'd0, 5'd0, 5'd4, 5'd0), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_SLTU, 5'd2, 5'd1, 5'd5, 5'd0), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_SLL, 5'd0, 5'd1, 5'd6, 5'd31), 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_SRL, 5'd0, 5'd1, 5'd6, 5'd31), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_SLTIU, 5'd0, 5'd7, 16'hFFFF), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_ANDI, 5'd1, 5'd7, 16'hFFFF), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_LW, 5'd1, 5'd8, 16'h0), 32'hFFFF_FFFF, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_ADDU, 5'd8, 5'd8, 5'd9, 5'd0), 32'hFFFF_FFFF, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_LW, 5'd0, 5'd10, 16'h4), 32'hA5A5_5A5A, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_SW, 5'd0, 5'd10, 16'h8), 32'h5A5A_A5A5, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_ADDU, 5'd1, 5'd1, 5'd0, 5'd0), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_BEQ, 5'd0, 5'd0, 16'h1), 32'd0, 1'b0, '0},
			'{enc_i(fsp_pkg::OP_BNE, 5'd1, 5'd0, 16'h1), 32'd0, 1'b0, '0},
			'{{fsp_pkg::OP_JAL, 26'h010_0010}, 32'd0, 1'b0, '0},
			'{enc_r(fsp_pkg::FN_JR, fsp_pkg::REG_LINK, 5'd0, 5'd0, 5'd0), 32'd0, 1'b0, '0},
			'{{fsp_pkg::OP_J, 26'h010_0000}, 32'd0, 1'b0, '0},
			'{32'hFC00_0000, 32'd0, 1'b0, '0},
			'{enc_r(6'h3F, 5'd1, 5'd2, 5'd3, 5'd0), 32'd0, 1'b0, '0}
		};
		foreach (rows[i])
			offer(rows[i].iw, rows[i].ld, rows[i].typed, rows[i].res);
		settle();

		// random phases over several text windows, extremes among them
		foreach (starts[p]) begin
			reg_write(fsp_pkg::REG_TEXT_START, starts[p]);
			reg_write(fsp_pkg::REG_TEXT_END, ends[p]);
			repeat (120)
				offer(rand_instr(), $urandom, 1'b0, '0);
			settle();
		end
		reg_write(fsp_pkg::REG_TEXT_START, $urandom);
		reg_write(fsp_pkg::REG_TEXT_END, 32'hFFFF_FFFF);
		repeat (40)
			offer($urandom, $urandom, 1'b0, '0);
		settle();

		$display("%0d ticks driven, %0d results checked, %0d retired, %0d stores, 11 windows",
			accepted, results, retires, stores);
		if (errors == 0 && ticks_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2ms;
		$display("Mismatches found");
		$finish;
	end
endmodule
